/* rtl/sfrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_pkg: shared types and constants of the serial frame receive checker
// Opcodes, status codes, register indexes and the request/result records.
// ----------------------------------------------------------------------------
package sfrc_pkg;

  // Frame geometry
  localparam int unsigned MAX_FRAME_LEN = 1024;
  localparam int unsigned LEN_W         = 11;   // frame_length / byte counter
  localparam int unsigned IDX_W         = 10;   // data_index
  localparam int unsigned CNT_W         = 24;   // poll counter / timeout_limit

  localparam logic [LEN_W-1:0] MAX_LEN_C   = LEN_W'(MAX_FRAME_LEN);
  localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};

  // Register reset values
  localparam logic [LEN_W-1:0] FRAME_LEN_RST   = LEN_W'(128);
  localparam logic [CNT_W-1:0] TIMEOUT_RST     = CNT_W'(125000);
  localparam logic             CMD_LEVEL_RST   = 1'b1;

  // Configuration register indexes
  localparam int unsigned      CFG_IDX_W        = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_LEVEL    = 2'd2;
  localparam int unsigned      CFG_DATA_W       = 24;

  // Request opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_POLL  = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_RECEIVING    = 3'd0;
  localparam logic [2:0] ST_OK           = 3'd1;
  localparam logic [2:0] ST_CHECKSUM_BAD = 3'd2;
  localparam logic [2:0] ST_CMD_CHANGED  = 3'd3;
  localparam logic [2:0] ST_TIMEOUT      = 3'd4;
  localparam logic [2:0] ST_FRAMING      = 3'd5;
  localparam logic [2:0] ST_OVERRUN      = 3'd6;
  localparam logic [2:0] ST_IDLE         = 3'd7;

  // Configuration snapshot
  typedef struct packed {
    logic [LEN_W-1:0] frame_length;
    logic [CNT_W-1:0] timeout_limit;
    logic             expected_cmd_level;
  } cfg_t;

  // One request
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic       framing_error;
    logic       overrun_error;
    logic       cmd_line_level;
  } req_t;

  // One result
  typedef struct packed {
    logic [2:0]       status;
    logic             data_valid;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] data_index;
  } res_t;

endpackage

/* rtl/sfrc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_cfg_regs: configuration register file
// Holds frame length, timeout limit and expected command level.
// ----------------------------------------------------------------------------
module sfrc_cfg_regs
  import sfrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_length       <= FRAME_LEN_RST;
      cfg_r.timeout_limit      <= TIMEOUT_RST;
      cfg_r.expected_cmd_level <= CMD_LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_LENGTH: cfg_r.frame_length       <= cfg_data[LEN_W-1:0];
        CFG_TIMEOUT:      cfg_r.timeout_limit      <= cfg_data[CNT_W-1:0];
        CFG_CMD_LEVEL:    cfg_r.expected_cmd_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/sfrc_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_in_reg: input register stage
// Captures one request per cycle while the core keeps taking; refills while the core takes the held one.
// ----------------------------------------------------------------------------
module sfrc_in_reg
  import sfrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic req_valid,
  input  logic req_take,
  output req_t req
);

  logic valid_r;
  req_t req_r;

  assign in_ready  = !valid_r || req_take;
  assign req_valid = valid_r;
  assign req       = req_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_req;
    end
  end

endmodule

/* rtl/sfrc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_core: frame state, checks and result register
// Evaluates one request per cycle, while the result channel is not stalled,
// against the frame state and registers the status and data byte.
// ----------------------------------------------------------------------------
module sfrc_core
  import sfrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic req_valid,
  output logic req_take,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic             active_r,  active_nxt;
  logic [LEN_W-1:0] bytes_r,   bytes_nxt;
  logic [7:0]       sum_r,     sum_nxt;
  logic [CNT_W-1:0] polls_r,   polls_nxt;
  logic             out_valid_r;
  res_t             res_r,     res_nxt;

  logic [LEN_W-1:0] eff_len;
  logic [8:0]       sum_wide;
  logic [7:0]       sum_add;

  assign req_take  = req_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = res_r;

  // Effective length clamp and end-around-carry sum
  assign eff_len  = (cfg.frame_length > MAX_LEN_C) ? MAX_LEN_C : cfg.frame_length;
  assign sum_wide = {1'b0, sum_r} + {1'b0, req.rx_byte};
  assign sum_add  = sum_wide[8] ? (sum_wide[7:0] + 8'd1) : sum_wide[7:0];

  // Next frame state and result
  always_comb begin
    active_nxt         = active_r;
    bytes_nxt          = bytes_r;
    sum_nxt            = sum_r;
    polls_nxt          = polls_r;
    res_nxt.status     = ST_RECEIVING;
    res_nxt.data_valid = 1'b0;
    res_nxt.data_byte  = 8'd0;
    res_nxt.data_index = '0;
    priority if (req.opcode == OP_START) begin
      active_nxt = 1'b1;
      bytes_nxt  = '0;
      sum_nxt    = 8'd0;
      polls_nxt  = '0;
    end else if (!active_r) begin
      res_nxt.status = ST_IDLE;
    end else if (req.opcode != OP_POLL && req.opcode != OP_BYTE) begin
      res_nxt.status = ST_RECEIVING;
    end else if (req.cmd_line_level != cfg.expected_cmd_level) begin
      res_nxt.status = ST_CMD_CHANGED;
      active_nxt     = 1'b0;
    end else if (polls_r > cfg.timeout_limit) begin
      res_nxt.status = ST_TIMEOUT;
      active_nxt     = 1'b0;
    end else begin
      if (polls_r != COUNT_MAX) begin
        polls_nxt = polls_r + CNT_W'(1);
      end
      if (req.opcode == OP_BYTE) begin
        priority if (req.framing_error) begin
          res_nxt.status = ST_FRAMING;
          active_nxt     = 1'b0;
        end else if (req.overrun_error) begin
          res_nxt.status = ST_OVERRUN;
          active_nxt     = 1'b0;
        end else if (bytes_r >= eff_len) begin
          res_nxt.status = (req.rx_byte == sum_r) ? ST_OK : ST_CHECKSUM_BAD;
          active_nxt     = 1'b0;
        end else begin
          res_nxt.data_valid = 1'b1;
          res_nxt.data_byte  = req.rx_byte;
          res_nxt.data_index = bytes_r[IDX_W-1:0];
          sum_nxt            = sum_add;
          bytes_nxt          = bytes_r + LEN_W'(1);
        end
      end
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      bytes_r  <= '0;
      sum_r    <= 8'd0;
      polls_r  <= '0;
    end else if (req_take) begin
      active_r <= active_nxt;
      bytes_r  <= bytes_nxt;
      sum_r    <= sum_nxt;
      polls_r  <= polls_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || res_ready) begin
      out_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      res_r <= res_nxt;
    end
  end

  // A start always opens a fresh frame
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    req_take && req.opcode == OP_START |=> active_r && bytes_r == '0 && polls_r == '0)
    else $error("start did not open a fresh frame");

  // Handed-out data only while receiving
  a_data_receiving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.data_valid |-> res_r.status == ST_RECEIVING)
    else $error("data byte with ending status");

  // Byte counter never passes the clamped maximum
  a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_r <= MAX_LEN_C)
    else $error("byte counter beyond maximum frame length");

  // Idle requests leave the frame state alone
  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    req_take && !active_r && req.opcode != OP_START |=>
      !active_r && $stable(sum_r) && $stable(bytes_r))
    else $error("idle request changed the frame state");

endmodule

/* rtl/serial_frame_receive_checker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receive_checker_unit: serial data frame checksum checker
// Path: an accepted request passes the input register, then the result
//   register, and is offered on the result channel from there; a stalled
//   result channel holds it back in the input register.
// Throughput: one request per cycle while the result channel is not stalled.
// Reset (rst_n low, synchronous): no frame active, counters and sum cleared,
//   registers back to length 128, timeout 125000, command level 1.
// ----------------------------------------------------------------------------
module serial_frame_receive_checker_unit
  import sfrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // rx_byte[7:0], framing_error[8],
                                            // overrun_error[9], cmd_line_level[10]
  input  logic [1:0]            in_tuser,   // opcode[1:0]
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // data_byte[7:0], data_index[17:8]
  output logic [3:0]            out_tuser,  // status[2:0], data_valid[3]
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  req_t in_req;
  req_t req;
  res_t res;
  logic req_valid;
  logic req_take;

  // Unpack request
  assign in_req.opcode         = in_tuser;
  assign in_req.rx_byte        = in_tdata[7:0];
  assign in_req.framing_error  = in_tdata[8];
  assign in_req.overrun_error  = in_tdata[9];
  assign in_req.cmd_line_level = in_tdata[10];

  sfrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfrc_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_req),
    .req_valid (req_valid),
    .req_take  (req_take),
    .req       (req)
  );

  sfrc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_take  (req_take),
    .req       (req),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack result
  assign out_tdata = {6'd0, res.data_index, res.data_byte};
  assign out_tuser = {res.data_valid, res.status};

endmodule
